// ===== sv/assert_macros.svh =====
// Shared assertion macros for the page allocator checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define RPA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define RPA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/rpa_pkg.sv =====
package rpa_pkg;

  // Page space and field widths
  localparam int NUM_PAGES  = 32768;
  localparam int PAGE_W     = 15;
  localparam int PAGE_AW    = $clog2(NUM_PAGES);
  localparam int DEPTH_W    = PAGE_AW + 1;
  localparam int COUNT_BITS = 16;
  localparam int COUNT_W    = 16;
  localparam int STATUS_W   = 2;
  localparam int CMD_W      = 3;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Saturation limits of a reference count
  localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
  localparam logic signed [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
  localparam logic signed [COUNT_BITS-1:0] CNT_ZERO = '0;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREE    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD_REF = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DROP    = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  // Register indexes on the configuration port
  localparam logic REG_FIRST_FREE = 1'b0;

  // Memory access bundle from the sequencer to the store
  typedef struct packed {
    logic                         rd_en;
    logic [PAGE_AW-1:0]           count_rd_addr;
    logic [PAGE_AW-1:0]           stack_rd_addr;
    logic                         count_we;
    logic [PAGE_AW-1:0]           count_wr_addr;
    logic signed [COUNT_BITS-1:0] count_wdata;
    logic                         stack_we;
    logic [PAGE_AW-1:0]           stack_wr_addr;
    logic [PAGE_W-1:0]            stack_wdata;
  } rpa_mem_req_t;

endpackage

// ===== sv/rpa_store.sv =====
module rpa_store
  import rpa_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  rpa_mem_req_t                 req,
  output logic                         clearing,
  output logic signed [COUNT_BITS-1:0] count_rd,
  output logic [PAGE_W-1:0]            stack_rd
);

  logic signed [COUNT_BITS-1:0] count_mem [NUM_PAGES];
  logic [PAGE_W-1:0]            stack_mem [NUM_PAGES];

  logic [PAGE_AW-1:0]           clr_addr;
  logic                         count_we;
  logic [PAGE_AW-1:0]           count_wr_addr;
  logic signed [COUNT_BITS-1:0] count_wdata;

  // Sweep the count memory to one after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + PAGE_AW'(1);
      if (clr_addr == PAGE_AW'(NUM_PAGES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Steer the count write port between the sweep and the sequencer
  always_comb begin
    if (clearing) begin
      count_we      = 1'b1;
      count_wr_addr = clr_addr;
      count_wdata   = CNT_ONE;
    end else begin
      count_we      = req.count_we;
      count_wr_addr = req.count_wr_addr;
      count_wdata   = req.count_wdata;
    end
  end

  // Count memory
  always_ff @(posedge clk) begin
    if (count_we) begin
      count_mem[count_wr_addr] <= count_wdata;
    end
    if (req.rd_en) begin
      count_rd <= count_mem[req.count_rd_addr];
    end
  end

  // Free stack memory
  always_ff @(posedge clk) begin
    if (req.stack_we) begin
      stack_mem[req.stack_wr_addr] <= req.stack_wdata;
    end
    if (req.rd_en) begin
      stack_rd <= stack_mem[req.stack_rd_addr];
    end
  end

endmodule

// ===== sv/refcounted_page_allocator.sv =====
// Page allocator with a saturating signed reference count per page and a LIFO
// free stack, both held in single-port-write synchronous RAMs. The accept cycle
// reads the page's count and the stack top; the EXEC state then computes the
// result, writes back and loads the output register once the output side can
// take it, so a new command is taken only after the last result is loaded.
// After reset the count RAM is swept to one, one entry a cycle; commands stall
// during the sweep, configuration writes are taken throughout. The free stack
// starts empty and is filled by free commands.
module refcounted_page_allocator
  import rpa_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  // APB configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [PDATA_W-1:0]         pwdata,
  output logic [PDATA_W-1:0]         prdata,
  output logic                       pready,
  // Command channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [CMD_W-1:0]           cmd,
  input  logic [PAGE_W-1:0]          page_index,
  // Result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_W-1:0]        status,
  output logic [PAGE_W-1:0]          alloc_page,
  output logic signed [COUNT_W-1:0]  ref_count,
  output logic                       was_last_ref,
  output logic                       page_released
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t                       state;
  logic [PAGE_W-1:0]            first_free_page;
  logic [DEPTH_W-1:0]           stack_depth;
  logic [DEPTH_W-1:0]           stack_depth_next;
  logic [DEPTH_W-1:0]           depth_dec;
  logic [CMD_W-1:0]             cmd_q;
  logic [PAGE_W-1:0]            page_q;

  rpa_mem_req_t                 mem_req;
  logic                         clearing;
  logic signed [COUNT_BITS-1:0] count_rd;
  logic [PAGE_W-1:0]            stack_rd;

  logic                         accept;
  logic                         finish;
  logic                         page_ok;
  logic                         popped_ok;
  logic signed [COUNT_BITS-1:0] cnt_inc;
  logic signed [COUNT_BITS-1:0] cnt_dec;
  logic signed [COUNT_BITS-1:0] cnt_res;

  logic [STATUS_W-1:0]          status_next;
  logic [PAGE_W-1:0]            alloc_page_next;
  logic                         last_next;
  logic                         released_next;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_free_page <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_FIRST_FREE)) begin
      first_free_page <= pwdata[PAGE_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_FIRST_FREE) begin
      prdata = PDATA_W'(first_free_page);
    end else begin
      prdata = '0;
    end
  end

  // Handshake
  assign in_stall = clearing || (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign finish   = (state == ST_EXEC) && (!out_valid || !out_stall);

  assign depth_dec = stack_depth - DEPTH_W'(1);

  // Saturating count arithmetic on the read-back value
  assign cnt_inc   = (count_rd == CNT_MAX) ? count_rd : count_rd + CNT_ONE;
  assign cnt_dec   = (count_rd == CNT_MIN) ? count_rd : count_rd - CNT_ONE;
  assign page_ok   = ({1'b0, page_q} < (PAGE_W + 1)'(NUM_PAGES));
  assign popped_ok = ({1'b0, stack_rd} < (PAGE_W + 1)'(NUM_PAGES));

  // Execute one command: compute the result and the write-back
  always_comb begin
    mem_req               = '0;
    mem_req.rd_en         = accept;
    mem_req.count_rd_addr = page_index[PAGE_AW-1:0];
    mem_req.stack_rd_addr = depth_dec[PAGE_AW-1:0];
    mem_req.count_wr_addr = page_q[PAGE_AW-1:0];
    mem_req.stack_wr_addr = stack_depth[PAGE_AW-1:0];
    mem_req.stack_wdata   = page_q;

    stack_depth_next = stack_depth;
    status_next      = STATUS_OK;
    alloc_page_next  = '0;
    cnt_res          = CNT_ZERO;
    last_next        = 1'b0;
    released_next    = 1'b0;

    case (cmd_q)
      CMD_ALLOC: begin
        if (stack_depth == '0) begin
          status_next = STATUS_EMPTY;
        end else begin
          stack_depth_next      = depth_dec;
          alloc_page_next       = stack_rd;
          cnt_res               = CNT_ONE;
          mem_req.count_we      = popped_ok;
          mem_req.count_wr_addr = stack_rd[PAGE_AW-1:0];
          mem_req.count_wdata   = CNT_ONE;
        end
      end
      CMD_FREE: begin
        if (!page_ok) begin
          status_next = STATUS_RANGE;
        end else begin
          mem_req.count_we    = 1'b1;
          mem_req.count_wdata = cnt_dec;
          cnt_res             = cnt_dec;
          if (cnt_dec == CNT_ZERO && count_rd != CNT_ZERO) begin
            if (page_q < first_free_page) begin
              status_next = STATUS_RANGE;
            end else if (stack_depth < DEPTH_W'(NUM_PAGES)) begin
              mem_req.stack_we = 1'b1;
              stack_depth_next = stack_depth + DEPTH_W'(1);
              released_next    = 1'b1;
            end
          end
        end
      end
      CMD_ADD_REF: begin
        if (page_ok) begin
          mem_req.count_we    = 1'b1;
          mem_req.count_wdata = cnt_inc;
          cnt_res             = cnt_inc;
        end
      end
      CMD_READ: begin
        if (page_ok) begin
          cnt_res = count_rd;
        end
      end
      CMD_DROP: begin
        if (page_ok) begin
          if (count_rd == CNT_ONE) begin
            last_next = 1'b1;
            cnt_res   = count_rd;
          end else begin
            mem_req.count_we    = 1'b1;
            mem_req.count_wdata = cnt_dec;
            cnt_res             = cnt_dec;
          end
        end
      end
      default: begin
      end
    endcase

    // Commit memory writes only when the result is loaded
    if (!finish) begin
      mem_req.count_we = 1'b0;
      mem_req.stack_we = 1'b0;
      stack_depth_next = stack_depth;
    end
  end

  // Sequencer, stack pointer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      stack_depth <= '0;
      out_valid   <= 1'b0;
    end else begin
      stack_depth <= stack_depth_next;
      // Raise the result when loaded, drop it once taken
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (finish) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Command and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= cmd;
      page_q <= page_index;
    end
    if (finish) begin
      status        <= status_next;
      alloc_page    <= alloc_page_next;
      ref_count     <= COUNT_W'(cnt_res);
      was_last_ref  <= last_next;
      page_released <= released_next;
    end
  end

  rpa_store u_store (
    .clk      (clk),
    .rst      (rst),
    .req      (mem_req),
    .clearing (clearing),
    .count_rd (count_rd),
    .stack_rd (stack_rd)
  );

endmodule

// ===== sv/rpa_checker.sv =====
`include "assert_macros.svh"

module rpa_checker
  import rpa_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [STATUS_W-1:0]       status,
  input logic [PAGE_W-1:0]         alloc_page,
  input logic signed [COUNT_W-1:0] ref_count,
  input logic                      was_last_ref,
  input logic                      page_released
);

  // A taken command stalls the command channel in the following cycle
  `RPA_ASSERT(a_stall_after_accept, (in_valid && !in_stall) |=> in_stall, "no stall after accept")

  // A stalled result stays offered
  `RPA_ASSERT(a_out_hold, (out_valid && out_stall) |=> out_valid, "stalled result dropped")

  // An empty-stack alloc carries no page and no count
  `RPA_ASSERT(a_empty_zero, (out_valid && status == STATUS_EMPTY) |-> (alloc_page == '0 && ref_count == '0), "empty alloc with payload")

  // A released page was freed cleanly down to zero
  `RPA_ASSERT(a_release_zero, (out_valid && page_released) |-> (status == STATUS_OK && ref_count == '0 && !was_last_ref), "bad release result")

  // A last-reference drop leaves the count at one
  `RPA_ASSERT(a_last_one, (out_valid && was_last_ref) |-> (ref_count == COUNT_W'(1) && status == STATUS_OK), "bad last-reference result")

endmodule

bind refcounted_page_allocator rpa_checker u_rpa_checker (.*);

// ===== tb/sv/refcounted_page_allocator_tb.sv =====
module refcounted_page_allocator_tb;
  import rpa_pkg::*;

  // Command codes the block must answer with an all-zero result
  localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

  localparam logic [PADDR_W-1:0] FIRST_FREE_ADDR = PADDR_W'(4 * REG_FIRST_FREE);
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [PAGE_W-1:0]         alloc_page;
    logic signed [COUNT_W-1:0] ref_count;
    logic                      was_last_ref;
    logic                      page_released;
  } page_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [PADDR_W-1:0]         paddr = '0;
  logic [PDATA_W-1:0]         pwdata = '0;
  logic [PDATA_W-1:0]         prdata;
  logic                       pready;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [CMD_W-1:0]           cmd = '0;
  logic [PAGE_W-1:0]          page_index = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [STATUS_W-1:0]        status;
  logic [PAGE_W-1:0]          alloc_page;
  logic signed [COUNT_W-1:0]  ref_count;
  logic                       was_last_ref;
  logic                       page_released;

  // Shadow copy of the allocator state
  int                page_counts [NUM_PAGES];
  logic [PAGE_W-1:0] free_pages [$];
  int                first_free;

  page_result_t pending_results [$];
  page_result_t oldest;
  int           errors = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  logic         hold_off = 1'b0;
  int unsigned  cmds_accepted = 0;

  refcounted_page_allocator u_top (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .page_index    (page_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .alloc_page    (alloc_page),
    .ref_count     (ref_count),
    .was_last_ref  (was_last_ref),
    .page_released (page_released)
  );

  always #4 clk = ~clk;

  // Stall the result channel at random, or solidly during a hold-off
  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  function automatic int saturate(int v);
    if (v > int'(CNT_MAX)) return int'(CNT_MAX);
    if (v < int'(CNT_MIN)) return int'(CNT_MIN);
    return v;
  endfunction

  // Apply one command to the shadow state and return the result it must give
  function automatic page_result_t apply_command(logic [CMD_W-1:0] op, logic [PAGE_W-1:0] page);
    page_result_t r;
    int           prior;
    int           next;
    logic         in_range;
    r = '0;
    in_range = int'(page) < NUM_PAGES;
    case (op)
      CMD_ALLOC: begin
        if (free_pages.size() == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.alloc_page = free_pages.pop_back();
          page_counts[r.alloc_page] = int'(CNT_ONE);
          r.ref_count = CNT_ONE;
        end
      end
      CMD_FREE: begin
        if (!in_range) begin
          r.status = STATUS_RANGE;
        end else begin
          prior = page_counts[page];
          next = saturate(prior - 1);
          page_counts[page] = next;
          if (next == 0 && prior != 0) begin
            if (int'(page) < first_free) begin
              r.status = STATUS_RANGE;
            end else if (free_pages.size() < NUM_PAGES) begin
              free_pages.push_back(page);
              r.page_released = 1'b1;
            end
          end
          r.ref_count = COUNT_W'(next);
        end
      end
      CMD_ADD_REF: begin
        if (in_range) begin
          page_counts[page] = saturate(page_counts[page] + 1);
          r.ref_count = COUNT_W'(page_counts[page]);
        end
      end
      CMD_READ: begin
        if (in_range) r.ref_count = COUNT_W'(page_counts[page]);
      end
      CMD_DROP: begin
        if (in_range) begin
          if (page_counts[page] == int'(CNT_ONE)) r.was_last_ref = 1'b1;
          else page_counts[page] = saturate(page_counts[page] - 1);
          r.ref_count = COUNT_W'(page_counts[page]);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one command, hold it until taken, then record its outcome
  task automatic issue_command(logic [CMD_W-1:0] op, logic [PAGE_W-1:0] page);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    page_index <= page;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_command(op, page));
    cmds_accepted++;
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_first_free(logic [PAGE_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= FIRST_FREE_ADDR;
    pwdata <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    first_free = int'(value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Mostly pages around the first free page, sometimes anywhere
  function automatic logic [PAGE_W-1:0] pick_page();
    int lo;
    int hi;
    if ($urandom_range(3) == 0) return PAGE_W'($urandom);
    lo = (first_free >= 8) ? first_free - 8 : 0;
    hi = (lo + 23 > NUM_PAGES - 1) ? NUM_PAGES - 1 : lo + 23;
    return PAGE_W'($urandom_range(hi, lo));
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Compare each taken result with the oldest outstanding expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual status %0d page %0d count %0d",
                 $time, status, alloc_page, ref_count);
      end else begin
        oldest = pending_results.pop_front();
        check_field("status", oldest.status, status);
        check_field("alloc_page", oldest.alloc_page, alloc_page);
        check_field("ref_count", oldest.ref_count, ref_count);
        check_field("was_last_ref", oldest.was_last_ref, was_last_ref);
        check_field("page_released", oldest.page_released, page_released);
      end
    end
  end

  // Field extremes, every command and the range, empty and last-reference cases
  task automatic test_directed();
    write_first_free(15'h7FFF);
    issue_command(CMD_ALLOC, 15'h7FFF);
    issue_command(CMD_FREE, 15'h7FFE);
    issue_command(CMD_FREE, 15'h7FFF);
    issue_command(CMD_ALLOC, 15'h0000);
    drop_valid();
    wait_drained();
    write_first_free(15'd100);
    issue_command(CMD_RSVD5, 15'h5555);
    issue_command(CMD_RSVD6, 15'h2AAA);
    issue_command(CMD_RSVD7, 15'h7FFF);
    issue_command(CMD_READ, 15'h0000);
    issue_command(CMD_READ, 15'h7FFF);
    // out of range, then below zero
    issue_command(CMD_FREE, 15'd50);
    issue_command(CMD_FREE, 15'd50);
    issue_command(CMD_FREE, 15'd50);
    repeat (3) issue_command(CMD_ADD_REF, 15'd50);
    // push at the boundary, pop LIFO until empty
    issue_command(CMD_FREE, 15'd100);
    issue_command(CMD_FREE, 15'd300);
    issue_command(CMD_ALLOC, 15'h7FFF);
    issue_command(CMD_ALLOC, 15'h0000);
    issue_command(CMD_ALLOC, 15'h2AAA);
    issue_command(CMD_ADD_REF, 15'd300);
    issue_command(CMD_DROP, 15'd300);
    issue_command(CMD_DROP, 15'd300);
    issue_command(CMD_READ, 15'd300);
    drop_valid();
    wait_drained();
  endtask

  // Page lifecycles with random content, mixed with stray commands
  task automatic test_random(int items, int snd_pct, int rcv_pct, logic [PAGE_W-1:0] base);
    int unsigned      stop_at;
    int               n;
    logic [PAGE_W-1:0] page;
    write_first_free(base);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    stop_at = cmds_accepted + items;
    while (cmds_accepted < stop_at) begin
      if ($urandom_range(99) < 70) begin
        if (free_pages.size() > 0 && $urandom_range(1) == 1) begin
          page = free_pages[$];
          issue_command(CMD_ALLOC, PAGE_W'($urandom));
          n = $urandom_range(3);
          repeat (n) issue_command(CMD_ADD_REF, page);
          repeat ($urandom_range(n + 1)) issue_command(CMD_DROP, page);
          if ($urandom_range(1) == 1) issue_command(CMD_READ, page);
          repeat ($urandom_range(2, 1)) issue_command(CMD_FREE, page);
        end else begin
          page = pick_page();
          if ($urandom_range(3) == 0) issue_command(CMD_ADD_REF, page);
          issue_command(CMD_FREE, page);
        end
      end else begin
        issue_command(CMD_W'($urandom), pick_page());
      end
    end
    drop_valid();
    wait_drained();
  endtask

  // Fill the block against a held receiver, then pause the sender until empty
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        @(negedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off <= 1'b0;
      end
    join_none
    repeat (40) issue_command(($urandom_range(1) == 1) ? CMD_ADD_REF : CMD_READ, pick_page());
    drop_valid();
    wait_drained();
    repeat (10) issue_command(CMD_DROP, pick_page());
    drop_valid();
    wait_drained();
  endtask

  initial begin
    foreach (page_counts[i]) page_counts[i] = int'(CNT_ONE);
    first_free = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random(440, 29, 55, '0);
    test_random(440, 55, 29, PAGE_W'($urandom_range(NUM_PAGES - 1)));
    test_random(450, 0, 0, PAGE_W'($urandom_range(NUM_PAGES / 8)));
    test_backpressure();

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
